// ===== sv/sorat_pkg.sv =====
// Package for the segmented object reassembly tracker.
// Holds sizes, status codes, controller states and the control structs.
// It depends on nothing else.
package sorat_pkg;

	localparam int SLOTS        = 16;
	localparam int MAX_SEGMENTS = 128;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int SEG_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = SEG_W + 1;
	localparam logic [5:0] KIND_REPEAT = 6'd2;

	typedef enum logic [2:0] {
		STAT_UNKNOWN   = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_SIZE_UNK  = 3'd2,
		STAT_OVERRUN   = 3'd3,
		STAT_ACCEPTED  = 3'd4,
		STAT_CREATED   = 3'd5,
		STAT_EXISTS    = 3'd6,
		STAT_RANGE     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_RD, ST_PC1, ST_PC2, ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic scan_step;
		logic decide;
		logic rd;
		logic pc1;
		logic pc2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_done;
		logic hdr_op;
		logic found;
		logic embed;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/sorat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module sorat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/sorat_ctrl.sv =====
// Controller state machine of the reassembly tracker.
// Depends on sorat_pkg; drives the datapath by command struct only.
module sorat_ctrl
	import sorat_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  sts_t   sts,
	output logic   in_ready,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// State register; reset starts the mark clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:    if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (sts.scan_done) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (sts.hdr_op) begin
					state_d = (!sts.found && sts.embed) ? ST_RD : ST_OUT;
				end else begin
					state_d = sts.found ? ST_RD : ST_OUT;
				end
			end
			ST_RD:     state_d = ST_PC1;
			ST_PC1:    state_d = ST_PC2;
			ST_PC2:    state_d = ST_OUT;
			ST_OUT:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR:    cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_RD:     cmd.rd = 1'b1;
			ST_PC1:    cmd.pc1 = 1'b1;
			ST_PC2:    cmd.pc2 = 1'b1;
			ST_OUT:    cmd.emit = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// ===== sv/sorat_dp.sv =====
// Datapath of the reassembly tracker: slot table, mark memory and result register.
// Depends on sorat_pkg and sorat_ram; steered by sorat_ctrl.
module sorat_dp
	import sorat_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic         in_op,
	input  logic         in_last,
	input  logic [103:0] in_data,
	input  logic         m_ready,
	output logic         m_valid,
	output logic [87:0]  m_data,
	output logic [3:0]   m_user
);

	// Slot table.
	logic                slot_used_q  [SLOTS];
	logic [15:0]         slot_id_q    [SLOTS];
	logic [27:0]         slot_total_q [SLOTS];
	logic [5:0]          slot_kind_q  [SLOTS];
	logic [8:0]          slot_sub_q   [SLOTS];
	logic                bytes_unk_q  [SLOTS];
	logic [12:0]         bytes_q      [SLOTS];
	logic                cnt_unk_q    [SLOTS];
	logic [CNT_W-1:0]    cnt_q        [SLOTS];
	logic [SLOT_W-1:0]   oldest_q;

	// Latched request.
	logic                op_q;
	logic [15:0]         id_q;
	logic [14:0]         pn_q;
	logic [12:0]         psize_q;
	logic                plast_q;
	logic [12:0]         hsize_q;
	logic [27:0]         body_q;
	logic [5:0]          kind_q;
	logic [8:0]          sub_q;

	// Search and processing state.
	logic [SLOT_W-1:0]   idx_q;
	logic                match_q, free_q;
	logic [SLOT_W-1:0]   match_idx_q, free_idx_q, slot_q;
	logic                hdr_q, go_q;
	logic [27:0]         prod_q;

	// Result being built.
	logic [2:0]          r_status_q;
	logic [27:0]         r_off_q, r_cbody_q;
	logic [12:0]         r_len_q;
	logic                r_done_q;
	logic [5:0]          r_ckind_q;
	logic [8:0]          r_csub_q;
	logic                out_valid_q;

	// Mark memory, one row per slot.
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	logic [MAX_SEGMENTS-1:0] ram_wdata, row;

	sorat_ram #(.WIDTH(MAX_SEGMENTS), .DEPTH(SLOTS)) u_marks (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(cmd.rd), .raddr(slot_q), .rdata(row)
	);

	// Piece checks, shared by both processing steps.
	logic                inrange, dup, eff_unk;
	logic [12:0]         eff_bytes;
	logic [SEG_W-1:0]    seg;
	logic [28:0]         end_pos;
	logic [CNT_W-1:0]    cnt_eff;
	logic                cnt_eff_unk;
	logic [MAX_SEGMENTS-1:0] new_row, need;
	logic                all_set;
	logic [SLOT_W-1:0]   new_slot;
	logic                embed;

	always_comb begin
		seg       = pn_q[SEG_W-1:0];
		inrange   = pn_q < 15'(MAX_SEGMENTS);
		dup       = inrange && row[seg];
		eff_unk   = bytes_unk_q[slot_q] && plast_q;
		eff_bytes = bytes_unk_q[slot_q] ? psize_q : bytes_q[slot_q];
		end_pos   = {1'b0, prod_q} + 29'(psize_q);
		new_row   = row;
		new_row[seg] = 1'b1;
		cnt_eff     = plast_q ? (CNT_W'(seg) + CNT_W'(1)) : cnt_q[slot_q];
		cnt_eff_unk = plast_q ? 1'b0 : cnt_unk_q[slot_q];
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			need[k] = CNT_W'(k) < cnt_eff;
		end
		all_set  = &(new_row | ~need);
		new_slot = free_q ? free_idx_q : oldest_q;
		// A header that is not last and covers its header bytes carries segment 0.
		embed    = !plast_q && (psize_q >= hsize_q);
	end

	// Mark memory write: clearing pass, slot creation, or piece acceptance.
	logic accept;
	assign accept = cmd.pc2 && go_q && !(end_pos > {1'b0, slot_total_q[slot_q]}) && inrange;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '0;
		priority if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
		end else if (cmd.decide && op_q == 1'b0 && !match_q) begin
			ram_we    = 1'b1;
			ram_waddr = new_slot;
		end else if (accept) begin
			ram_we    = 1'b1;
			ram_wdata = (!cnt_eff_unk && all_set && slot_kind_q[slot_q] == KIND_REPEAT)
				? '0 : new_row;
		end else begin
			ram_we = 1'b0;
		end
	end

	// Control registers: slot use, piece sizes, counters, pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				slot_used_q[s] <= 1'b0;
				bytes_unk_q[s] <= 1'b1;
				cnt_unk_q[s]   <= 1'b1;
			end
			oldest_q    <= '0;
			idx_q       <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			go_q        <= 1'b0;
			hdr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step || cmd.scan_step) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (cmd.load) begin
				idx_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
				go_q    <= 1'b0;
				hdr_q   <= 1'b0;
			end
			// Scan one slot per cycle for the id and the lowest free slot.
			if (cmd.scan_step) begin
				if (!match_q && slot_used_q[idx_q] && slot_id_q[idx_q] == id_q) begin
					match_q <= 1'b1;
				end
				if (!free_q && !slot_used_q[idx_q]) begin
					free_q <= 1'b1;
				end
			end
			// Slot creation for a new id.
			if (cmd.decide && op_q == 1'b0 && !match_q) begin
				slot_used_q[new_slot] <= 1'b1;
				bytes_unk_q[new_slot] <= 1'b1;
				cnt_unk_q[new_slot]   <= 1'b1;
				hdr_q                 <= 1'b1;
				if (!free_q) begin
					oldest_q <= oldest_q + SLOT_W'(1);
				end
			end
			// First step of a piece: duplicate and size checks.
			if (cmd.pc1) begin
				go_q <= !dup && !eff_unk;
				if (!dup && !plast_q && bytes_unk_q[slot_q]) begin
					bytes_unk_q[slot_q] <= 1'b0;
				end
			end
			if (accept && plast_q) begin
				cnt_unk_q[slot_q] <= 1'b0;
			end
			// Output register.
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			plast_q <= in_last;
			id_q    <= in_data[15:0];
			pn_q    <= in_data[30:16];
			psize_q <= in_data[43:31];
			hsize_q <= in_data[56:44];
			body_q  <= in_data[84:57];
			kind_q  <= in_data[90:85];
			sub_q   <= in_data[99:91];
			r_status_q <= STAT_UNKNOWN;
			r_off_q    <= '0;
			r_len_q    <= '0;
			r_done_q   <= 1'b0;
			r_cbody_q  <= '0;
			r_ckind_q  <= '0;
			r_csub_q   <= '0;
		end
		if (cmd.scan_step) begin
			if (!match_q) match_idx_q <= idx_q;
			if (!free_q) free_idx_q <= idx_q;
		end
		if (cmd.decide) begin
			if (op_q == 1'b0) begin
				if (match_q) begin
					r_status_q <= STAT_EXISTS;
					slot_q     <= match_idx_q;
				end else begin
					r_status_q <= STAT_CREATED;
					slot_q     <= new_slot;
					slot_id_q[new_slot]    <= id_q;
					slot_total_q[new_slot] <= body_q;
					slot_kind_q[new_slot]  <= kind_q;
					slot_sub_q[new_slot]   <= sub_q;
					// The rest of a header segment becomes segment 0.
					pn_q    <= '0;
					psize_q <= psize_q - hsize_q;
				end
			end else begin
				slot_q <= match_q ? match_idx_q : '0;
			end
		end
		if (cmd.pc1) begin
			prod_q <= 28'(pn_q * eff_bytes);
			if (!dup && !plast_q && bytes_unk_q[slot_q]) begin
				bytes_q[slot_q] <= psize_q;
			end
			if (!hdr_q) begin
				r_status_q <= dup ? STAT_DUPLICATE : STAT_SIZE_UNK;
			end
		end
		if (cmd.pc2 && go_q) begin
			if (!hdr_q) begin
				priority if (end_pos > {1'b0, slot_total_q[slot_q]}) r_status_q <= STAT_OVERRUN;
				else if (!inrange) r_status_q <= STAT_RANGE;
				else r_status_q <= STAT_ACCEPTED;
			end
			if (accept) begin
				r_off_q <= prod_q;
				r_len_q <= psize_q;
				if (plast_q) cnt_q[slot_q] <= cnt_eff;
				if (!cnt_eff_unk && all_set) begin
					r_done_q  <= 1'b1;
					r_cbody_q <= slot_total_q[slot_q];
					r_ckind_q <= slot_kind_q[slot_q];
					r_csub_q  <= slot_sub_q[slot_q];
				end
			end
		end
		if (cmd.emit) begin
			m_user <= {r_done_q, r_status_q};
			m_data <= {r_csub_q, r_ckind_q, r_cbody_q, r_len_q, r_off_q, slot_q};
		end
	end

	assign m_valid = out_valid_q;

	always_comb begin
		sts.clr_done  = idx_q == SLOT_W'(SLOTS - 1);
		sts.scan_done = idx_q == SLOT_W'(SLOTS - 1);
		sts.hdr_op    = op_q == 1'b0;
		sts.found     = match_q;
		sts.embed     = embed;
		sts.out_free  = !out_valid_q || m_ready;
	end

endmodule

// ===== sv/segmented_object_reassembly_tracker_top.sv =====
// Segmented object reassembly tracker, top level.
// Input requests on s_axis, one result per request on m_axis. Operation
// travels in s_axis_tuser, last_flag in s_axis_tlast; status and
// object_complete travel in m_axis_tuser.
// A body segment for an id that is found, or a header that creates a slot
// and carries an embedded segment, passes through the id search over all
// slots, a decision step, a mark-row read, two processing steps and the
// load of the output register. Other requests skip the read and the
// processing steps. The slot search takes up most of the time that one
// request occupies.
// The next request is taken as soon as the result sits in the output
// register, even while the receiver stalls it; a stalled result holds,
// and the following result waits behind it with s_axis_tready low.
// After reset the block clears the mark memory, one row per cycle, with
// s_axis_tready low; slots are all free afterwards.
// Depends on sorat_pkg, sorat_ctrl, sorat_dp and sorat_ram.
module segmented_object_reassembly_tracker_top
	import sorat_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// transport_id, segment_number, segment_size, header_size, body_size,
	// content_type, content_subtype, zero fill
	input  logic [103:0] s_axis_tdata,
	// operation
	input  logic         s_axis_tuser,
	// last_flag
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot_index, write_offset, write_length, completed_body_size,
	// completed_content_type, completed_content_subtype
	output logic [87:0]  m_axis_tdata,
	// status, object_complete
	output logic [3:0]   m_axis_tuser
);

	cmd_t cmd;
	sts_t sts;

	sorat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .sts(sts),
		.in_ready(s_axis_tready), .cmd(cmd)
	);

	sorat_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(s_axis_tuser), .in_last(s_axis_tlast), .in_data(s_axis_tdata),
		.m_ready(m_axis_tready), .m_valid(m_axis_tvalid),
		.m_data(m_axis_tdata), .m_user(m_axis_tuser)
	);

endmodule
